// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the trie string counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: always");
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/tsc_pkg.sv =====
// Types and constants of the trie string counter.
package tsc_pkg;

	localparam int LETTER_W = 5;
	localparam int COUNT_W  = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_POOL_FULL = 1'b1;

	// One letter request of a word
	typedef struct packed {
		logic                opcode;
		logic [LETTER_W-1:0] letter;
		logic                last_letter;
	} letter_req_t;

	// One word result
	typedef struct packed {
		logic [COUNT_W-1:0] word_total;
		logic               status;
	} word_result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COUNT
	} tsc_state_t;

endpackage

// ===== hw/rtl/tsc_stream_if.sv =====
// Valid/ready stream interface carrying one request per handshake.
interface tsc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tsc_ram.sv =====
// Single-port synchronous RAM with registered read data.
module tsc_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// ===== hw/rtl/tsc_walk.sv =====
// Trie walk sequencer: clearing pass, child lookup, node allocation, count update.
`include "assert_macros.svh"
module tsc_walk #(
	parameter int NODES   = 4096,
	parameter int LETTERS = 26
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tsc_stream_if.sink                          letters,
	output logic                                child_re,
	output logic                                child_we,
	output logic [$clog2(NODES*LETTERS)-1:0]    child_addr,
	output logic [$clog2(NODES)-1:0]            child_wdata,
	input  logic [$clog2(NODES)-1:0]            child_rdata,
	output logic                                cnt_re,
	output logic                                cnt_we,
	output logic [$clog2(NODES)-1:0]            cnt_addr,
	output logic [tsc_pkg::COUNT_W-1:0]         cnt_wdata,
	input  logic [tsc_pkg::COUNT_W-1:0]         cnt_rdata,
	input  logic                                out_free,
	output logic                                push,
	output tsc_pkg::word_result_t               push_data
);
	import tsc_pkg::*;

	localparam int NODE_W      = $clog2(NODES);
	localparam int CHILD_DEPTH = NODES * LETTERS;
	localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

	tsc_state_t          state_q, state_d;
	logic [CHILD_AW-1:0] clr_q, clr_d;
	logic [NODE_W-1:0]   node_q, node_d;
	logic [NODE_W-1:0]   used_q, used_d;
	logic                lost_q, lost_d;
	logic                full_q, full_d;
	logic                walk_q, walk_d;
	letter_req_t         req_q;
	logic [CHILD_AW-1:0] addr_q;

	logic                accept;
	logic                in_range;
	logic [CHILD_AW-1:0] lookup_addr;
	logic [NODE_W-1:0]   new_node;
	logic                room;
	logic [NODE_W-1:0]   next_node;
	logic                path_ok;

	assign letters.ready = (state_q == ST_IDLE);
	assign accept        = letters.valid && letters.ready;
	assign in_range      = int'(letters.data.letter) < LETTERS;
	assign lookup_addr   = CHILD_AW'(node_q) * CHILD_AW'(LETTERS)
		+ CHILD_AW'(letters.data.letter);
	assign new_node      = used_q + NODE_W'(1);
	assign room          = ((NODE_W+1)'(used_q) + (NODE_W+1)'(1)) < (NODE_W+1)'(NODES);
	assign path_ok       = !lost_q && !full_q;

	// Next state, memory commands and result
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		node_d      = node_q;
		used_d      = used_q;
		lost_d      = lost_q;
		full_d      = full_q;
		walk_d      = walk_q;
		child_re    = 1'b0;
		child_we    = 1'b0;
		child_addr  = lookup_addr;
		child_wdata = '0;
		cnt_re      = 1'b0;
		cnt_we      = 1'b0;
		cnt_addr    = node_q;
		cnt_wdata   = '0;
		push        = 1'b0;
		push_data   = '{word_total: '0, status: STATUS_OK};
		next_node   = node_q;

		case (state_q)
			ST_CLEAR: begin
				// Zero one child entry and, while in range, one count per cycle
				child_we   = 1'b1;
				child_addr = clr_q;
				if (clr_q < CHILD_AW'(NODES)) begin
					cnt_we   = 1'b1;
					cnt_addr = clr_q[NODE_W-1:0];
				end
				clr_d = clr_q + CHILD_AW'(1);
				if (clr_q == CHILD_AW'(CHILD_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// Take a letter and look up the child link
				if (accept) begin
					walk_d   = path_ok && in_range;
					child_re = path_ok && in_range;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				// Follow the link, allocate a node or drop the rest of the word
				if (walk_q) begin
					if (child_rdata != '0) begin
						next_node = child_rdata;
					end else if (req_q.opcode == OP_INSERT) begin
						if (room) begin
							child_we    = 1'b1;
							child_addr  = addr_q;
							child_wdata = new_node;
							used_d      = new_node;
							next_node   = new_node;
						end else begin
							full_d = 1'b1;
						end
					end else begin
						lost_d = 1'b1;
					end
				end else if (path_ok) begin
					lost_d = 1'b1;
				end
				node_d = next_node;
				if (req_q.last_letter) begin
					cnt_re   = 1'b1;
					cnt_addr = next_node;
					state_d  = ST_COUNT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_COUNT: begin
				// Update the count on an insert and hand the result over once the output slot frees
				if (out_free) begin
					push = 1'b1;
					if (req_q.opcode == OP_INSERT) begin
						if (full_q) begin
							push_data.status = STATUS_POOL_FULL;
						end else if (!lost_q) begin
							cnt_we    = 1'b1;
							cnt_wdata = (cnt_rdata < COUNT_MAX) ? cnt_rdata + COUNT_W'(1)
								: cnt_rdata;
							push_data.word_total = cnt_wdata;
						end
					end else if (path_ok) begin
						push_data.word_total = cnt_rdata;
					end
					node_d  = '0;
					lost_d  = 1'b0;
					full_d  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			node_q  <= '0;
			used_q  <= '0;
			lost_q  <= 1'b0;
			full_q  <= 1'b0;
			walk_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			node_q  <= node_d;
			used_q  <= used_d;
			lost_q  <= lost_d;
			full_q  <= full_d;
			walk_q  <= walk_d;
		end
	end

	// Hold the request and its lookup address
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= letters.data;
			addr_q <= lookup_addr;
		end
	end

	`ASSERT_ALWAYS(a_pool_bound, clk, arst_n, (NODE_W+1)'(used_q) < (NODE_W+1)'(NODES))
	`ASSERT_IMPLIES(a_alloc_on_empty, clk, arst_n, child_we && state_q == ST_WALK, child_rdata == '0)
	`ASSERT_NEXT(a_alloc_advances, clk, arst_n, child_we && state_q == ST_WALK, used_q == NODE_W'($past(used_q) + NODE_W'(1)))
	`ASSERT_NEXT(a_word_end_root, clk, arst_n, push, node_q == '0 && !lost_q && !full_q)
	`ASSERT_IMPLIES(a_quiet_clear, clk, arst_n, state_q == ST_CLEAR, !child_re && !cnt_re && !letters.ready)
endmodule

// ===== hw/rtl/trie_string_counter.sv =====
// Trie string counter top level: walk sequencer, child and count memories, output register.
// Counts lower-case words in a prefix tree held in two single-port synchronous memories:
// a child table of NODES*LETTERS node links and a table of NODES 16-bit counts. Words
// arrive one letter per request on letters; each final letter yields one request on results
// with the word's count (after the increment for an insert, saturating at 65535) and a
// status bit set when an insert found the node pool exhausted. A letter that is not the
// last goes through accept, then the child table read and any link write; a last letter
// adds the count read-modify-write, which waits while a full output register drains.
// The output register lets the next letter be accepted while a result is still waiting.
// After reset a clearing pass zeroes both memories, one child entry per cycle, across
// all NODES*LETTERS entries (106496 at the defaults); no letter is accepted until it
// finishes.
module trie_string_counter #(
	parameter int NODES   = 4096,
	parameter int LETTERS = 26
) (
	input  logic         clk,
	input  logic         arst_n,
	tsc_stream_if.sink   letters,
	tsc_stream_if.source results
);
	import tsc_pkg::*;

	localparam int NODE_W   = $clog2(NODES);
	localparam int CHILD_AW = $clog2(NODES * LETTERS);

	logic                child_re;
	logic                child_we;
	logic [CHILD_AW-1:0] child_addr;
	logic [NODE_W-1:0]   child_wdata;
	logic [NODE_W-1:0]   child_rdata;
	logic                cnt_re;
	logic                cnt_we;
	logic [NODE_W-1:0]   cnt_addr;
	logic [COUNT_W-1:0]  cnt_wdata;
	logic [COUNT_W-1:0]  cnt_rdata;
	logic                out_free;
	logic                push;
	word_result_t        push_data;
	logic                out_valid_q;
	word_result_t        out_data_q;

	tsc_walk #(
		.NODES   (NODES),
		.LETTERS (LETTERS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.letters     (letters),
		.child_re    (child_re),
		.child_we    (child_we),
		.child_addr  (child_addr),
		.child_wdata (child_wdata),
		.child_rdata (child_rdata),
		.cnt_re      (cnt_re),
		.cnt_we      (cnt_we),
		.cnt_addr    (cnt_addr),
		.cnt_wdata   (cnt_wdata),
		.cnt_rdata   (cnt_rdata),
		.out_free    (out_free),
		.push        (push),
		.push_data   (push_data)
	);

	tsc_ram #(
		.DEPTH (NODES * LETTERS),
		.WIDTH (NODE_W)
	) u_child_mem (
		.clk   (clk),
		.re    (child_re),
		.we    (child_we),
		.addr  (child_addr),
		.wdata (child_wdata),
		.rdata (child_rdata)
	);

	tsc_ram #(
		.DEPTH (NODES),
		.WIDTH (COUNT_W)
	) u_count_mem (
		.clk   (clk),
		.re    (cnt_re),
		.we    (cnt_we),
		.addr  (cnt_addr),
		.wdata (cnt_wdata),
		.rdata (cnt_rdata)
	);

	assign out_free      = !out_valid_q || results.ready;
	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

	// Output request register: load on push, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q <= push_data;
		end
	end
endmodule
